FILE: sv/bisa_pkg.sv
// ============================================================================
// bisa_pkg
// Shared types and constants for the nearest-neighbor scaling address
// generator.
// ============================================================================
package bisa_pkg;

    localparam int CFG_W   = 12;   // configuration register width
    localparam int IDX_W   = 2;    // configuration register index width
    localparam int COORD_W = 11;   // target coordinate and fine step width
    localparam int ADDR_W  = 22;   // linear source index width
    localparam int DIV_W   = CFG_W;
    localparam int CNT_W   = $clog2(DIV_W);

    localparam int MAX_DIM_DEF = 2048;

    localparam logic [CFG_W-1:0] SRC_W_RST = CFG_W'(800);
    localparam logic [CFG_W-1:0] SRC_H_RST = CFG_W'(480);
    localparam logic [CFG_W-1:0] TGT_W_RST = CFG_W'(800);
    localparam logic [CFG_W-1:0] TGT_H_RST = CFG_W'(480);

    localparam logic [IDX_W-1:0] REG_SRC_W = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SRC_H = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_TGT_W = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_TGT_H = IDX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_DIV,
        ST_ROW_LOAD,
        ST_ROW_DIV,
        ST_MUL,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic start;        // latch dimensions, load column division
        logic div_step;     // one quotient bit
        logic row_load;     // keep column steps, load row division
        logic mul;          // scale row quotient by source width
        logic restart_out;  // clear frame position, emit pixel (0,0)
        logic advance;      // step one target pixel and emit it
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a new item
    } dp_status_t;

endpackage

FILE: sv/bresenham_image_scale_addr.sv
// ============================================================================
// bresenham_image_scale_addr
// Nearest-neighbor scaler address generator: walks the target frame in raster
// order and gives the linear source pixel index for each target pixel.
// ============================================================================
//  channel  handshake               payload
//  -------  ----------------------  ------------------------------------------
//  in       in_valid / in_ready     restart
//  out      out_valid / out_ready   source_index, target_x, target_y,
//                                   repeat_row, row_end, frame_end
//  cfg      cfg_write               cfg_index, cfg_data
//
//  An advance item is taken when the output register is free; items follow
//  back to back while it drains. A restart item waits for the shared
//  restoring divider (one quotient bit per cycle, two 12-bit divisions)
//  and a multiply. Reset loads the default dimensions and a 1x1 frame.
//  A stalled output holds the next item at the input.
// ============================================================================
module bresenham_image_scale_addr
#(
    parameter int MAX_DIM = bisa_pkg::MAX_DIM_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bisa_pkg::IDX_W-1:0]       cfg_index,
    input  logic [bisa_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bisa_pkg::ADDR_W-1:0]      source_index,
    output logic [bisa_pkg::COORD_W-1:0]     target_x,
    output logic [bisa_pkg::COORD_W-1:0]     target_y,
    output logic                             repeat_row,
    output logic                             row_end,
    output logic                             frame_end
);

    bisa_pkg::dp_cmd_t    cmd;
    bisa_pkg::dp_status_t status;

    bisa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .status   (status),
        .cmd      (cmd)
    );

    bisa_dpath
    #(
        .MAX_DIM (MAX_DIM)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .source_index (source_index),
        .target_x     (target_x),
        .target_y     (target_y),
        .repeat_row   (repeat_row),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

endmodule

FILE: sv/bisa_ctrl.sv
// ============================================================================
// bisa_ctrl
// Sequencer: accepts items, runs the restart divisions and issues datapath
// commands.
// ============================================================================
module bisa_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    input  bisa_pkg::dp_status_t  status,
    output bisa_pkg::dp_cmd_t     cmd
);

    bisa_pkg::ctl_state_t           state_reg, state_next;
    logic [bisa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           cnt_last;

    assign cnt_last = (cnt_reg == bisa_pkg::CNT_W'(bisa_pkg::DIV_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bisa_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            bisa_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid && status.out_free && restart)
                begin
                    state_next = bisa_pkg::ST_COL_DIV;
                end
            end
            bisa_pkg::ST_COL_DIV:
            begin
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = bisa_pkg::ST_ROW_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bisa_pkg::ST_ROW_LOAD:
            begin
                state_next = bisa_pkg::ST_ROW_DIV;
            end
            bisa_pkg::ST_ROW_DIV:
            begin
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = bisa_pkg::ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bisa_pkg::ST_MUL:
            begin
                state_next = bisa_pkg::ST_OUT;
            end
            bisa_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = bisa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bisa_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            bisa_pkg::ST_IDLE:
            begin
                in_ready    = status.out_free;
                cmd.start   = in_valid && status.out_free && restart;
                cmd.advance = in_valid && status.out_free && !restart;
            end
            bisa_pkg::ST_COL_DIV:  cmd.div_step    = 1'b1;
            bisa_pkg::ST_ROW_LOAD: cmd.row_load    = 1'b1;
            bisa_pkg::ST_ROW_DIV:  cmd.div_step    = 1'b1;
            bisa_pkg::ST_MUL:      cmd.mul         = 1'b1;
            bisa_pkg::ST_OUT:      cmd.restart_out = status.out_free;
            default:               cmd             = '0;
        endcase
    end

endmodule

FILE: sv/bisa_dpath.sv
// ============================================================================
// bisa_dpath
// Datapath: configuration registers, shared restoring divider, step
// accumulators and the output register.
// ============================================================================
module bisa_dpath
#(
    parameter int MAX_DIM = bisa_pkg::MAX_DIM_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bisa_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bisa_pkg::CFG_W-1:0]    cfg_data,
    input  bisa_pkg::dp_cmd_t             cmd,
    output bisa_pkg::dp_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bisa_pkg::ADDR_W-1:0]   source_index,
    output logic [bisa_pkg::COORD_W-1:0]  target_x,
    output logic [bisa_pkg::COORD_W-1:0]  target_y,
    output logic                          repeat_row,
    output logic                          row_end,
    output logic                          frame_end
);

    localparam int CW = bisa_pkg::CFG_W;
    localparam int XW = bisa_pkg::COORD_W;
    localparam int AW = bisa_pkg::ADDR_W;

    function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = CW'(1);
            end
            else if (32'(v) > 32'(MAX_DIM))
            begin
                r = CW'(MAX_DIM);
            end
            return r;
        end
    endfunction

    // configuration
    logic [CW-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= bisa_pkg::SRC_W_RST;
            src_h_reg <= bisa_pkg::SRC_H_RST;
            tgt_w_reg <= bisa_pkg::TGT_W_RST;
            tgt_h_reg <= bisa_pkg::TGT_H_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bisa_pkg::REG_SRC_W: src_w_reg <= cfg_data;
                bisa_pkg::REG_SRC_H: src_h_reg <= cfg_data;
                bisa_pkg::REG_TGT_W: tgt_w_reg <= cfg_data;
                bisa_pkg::REG_TGT_H: tgt_h_reg <= cfg_data;
                default:             src_w_reg <= src_w_reg;
            endcase
        end
    end

    // latched dimensions and steps
    logic [CW-1:0] lat_sw_reg, lat_sh_reg, lat_tw_reg, lat_th_reg;
    logic [XW-1:0] col_whole_reg, col_part_reg, row_part_reg;
    logic [AW-1:0] row_whole_reg;

    // divider
    logic [CW-1:0] div_rem_reg, div_rem_next;
    logic [CW-1:0] div_quo_reg, div_quo_next;
    logic [CW-1:0] div_den_reg, div_den_next;
    logic [CW:0]   div_shift, div_diff;
    logic [2*CW-1:0] row_prod;

    assign div_shift = {div_rem_reg, div_quo_reg[CW-1]};
    assign div_diff  = div_shift - {1'b0, div_den_reg};
    assign row_prod  = div_quo_reg * lat_sw_reg;

    always_comb
    begin
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        if (cmd.start)
        begin
            div_rem_next = '0;
            div_quo_next = clamp_dim(src_w_reg);
            div_den_next = clamp_dim(tgt_w_reg);
        end
        else if (cmd.row_load)
        begin
            div_rem_next = '0;
            div_quo_next = lat_sh_reg;
            div_den_next = lat_th_reg;
        end
        else if (cmd.div_step)
        begin
            // restoring step: keep the difference when it did not go negative
            div_rem_next = div_diff[CW] ? div_shift[CW-1:0] : div_diff[CW-1:0];
            div_quo_next = {div_quo_reg[CW-2:0], ~div_diff[CW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= '0;
            div_den_reg <= '0;
        end
        else
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            div_den_reg <= div_den_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_sw_reg    <= CW'(1);
            lat_sh_reg    <= CW'(1);
            lat_tw_reg    <= CW'(1);
            lat_th_reg    <= CW'(1);
            col_whole_reg <= '0;
            col_part_reg  <= '0;
            row_whole_reg <= '0;
            row_part_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                lat_sw_reg <= clamp_dim(src_w_reg);
                lat_sh_reg <= clamp_dim(src_h_reg);
                lat_tw_reg <= clamp_dim(tgt_w_reg);
                lat_th_reg <= clamp_dim(tgt_h_reg);
            end
            if (cmd.row_load)
            begin
                col_whole_reg <= div_quo_reg[XW-1:0];
                col_part_reg  <= div_rem_reg[XW-1:0];
            end
            if (cmd.mul)
            begin
                row_whole_reg <= row_prod[AW-1:0];
                row_part_reg  <= div_rem_reg[XW-1:0];
            end
        end
    end

    // frame position
    logic [XW-1:0] col_cnt_reg, col_cnt_next;
    logic [XW-1:0] row_cnt_reg, row_cnt_next;
    logic [XW-1:0] col_err_reg, col_err_next;
    logic [XW-1:0] row_err_reg, row_err_next;
    logic [XW-1:0] col_off_reg, col_off_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic          repeats_reg, repeats_next;

    logic [CW-1:0] col_cnt_inc, row_cnt_inc;
    logic          col_last, row_last;
    logic [CW-1:0] col_err_sum, col_err_adj, row_err_sum, row_err_adj;
    logic          col_carry, row_carry;
    logic [AW+1:0] row_base_sum;
    logic [CW-1:0] nxt_col_inc, nxt_row_inc;
    logic          nxt_row_end, nxt_frame_end;
    logic          load;

    assign col_cnt_inc = {1'b0, col_cnt_reg} + 1'b1;
    assign row_cnt_inc = {1'b0, row_cnt_reg} + 1'b1;
    assign col_last    = (col_cnt_inc >= lat_tw_reg);
    assign row_last    = (row_cnt_inc >= lat_th_reg);

    assign col_err_sum = {1'b0, col_err_reg} + {1'b0, col_part_reg};
    assign col_carry   = (col_err_sum >= lat_tw_reg);
    assign col_err_adj = col_carry ? col_err_sum - lat_tw_reg : col_err_sum;

    assign row_err_sum = {1'b0, row_err_reg} + {1'b0, row_part_reg};
    assign row_carry   = (row_err_sum >= lat_th_reg);
    assign row_err_adj = row_carry ? row_err_sum - lat_th_reg : row_err_sum;
    assign row_base_sum = {2'b00, row_base_reg} + {2'b00, row_whole_reg}
                        + (row_carry ? (AW+2)'(lat_sw_reg) : '0);

    always_comb
    begin
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        col_err_next  = col_err_reg;
        row_err_next  = row_err_reg;
        col_off_next  = col_off_reg;
        row_base_next = row_base_reg;
        repeats_next  = repeats_reg;
        if (cmd.restart_out || (cmd.advance && col_last && row_last))
        begin
            // new frame at pixel (0,0)
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            col_err_next  = '0;
            row_err_next  = '0;
            col_off_next  = '0;
            row_base_next = '0;
            repeats_next  = 1'b0;
        end
        else if (cmd.advance && col_last)
        begin
            col_cnt_next  = '0;
            col_err_next  = '0;
            col_off_next  = '0;
            row_base_next = row_base_sum[AW-1:0];
            repeats_next  = (row_base_sum[AW-1:0] == row_base_reg);
            row_err_next  = row_err_adj[XW-1:0];
            row_cnt_next  = row_cnt_inc[XW-1:0];
        end
        else if (cmd.advance)
        begin
            col_off_next = col_off_reg + col_whole_reg + XW'(col_carry);
            col_err_next = col_err_adj[XW-1:0];
            col_cnt_next = col_cnt_inc[XW-1:0];
        end
    end

    assign load          = cmd.restart_out || cmd.advance;
    assign nxt_col_inc   = {1'b0, col_cnt_next} + 1'b1;
    assign nxt_row_inc   = {1'b0, row_cnt_next} + 1'b1;
    assign nxt_row_end   = (nxt_col_inc >= lat_tw_reg);
    assign nxt_frame_end = nxt_row_end && (nxt_row_inc >= lat_th_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            col_err_reg  <= '0;
            row_err_reg  <= '0;
            col_off_reg  <= '0;
            row_base_reg <= '0;
            repeats_reg  <= 1'b0;
        end
        else
        begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            col_err_reg  <= col_err_next;
            row_err_reg  <= row_err_next;
            col_off_reg  <= col_off_next;
            row_base_reg <= row_base_next;
            repeats_reg  <= repeats_next;
        end
    end

    // output register
    logic          out_valid_reg;
    logic [AW-1:0] index_reg;
    logic [XW-1:0] x_reg, y_reg;
    logic          repeat_reg, row_end_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg     <= row_base_next + AW'(col_off_next);
            x_reg         <= col_cnt_next;
            y_reg         <= row_cnt_next;
            repeat_reg    <= repeats_next;
            row_end_reg   <= nxt_row_end;
            frame_end_reg <= nxt_frame_end;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign source_index    = index_reg;
    assign target_x        = x_reg;
    assign target_y        = y_reg;
    assign repeat_row      = repeat_reg;
    assign row_end         = row_end_reg;
    assign frame_end       = frame_end_reg;

endmodule

FILE: tb/sv/tb_bresenham_image_scale_addr.sv
// ============================================================================
// tb_bresenham_image_scale_addr
// Self-checking bench for the nearest-neighbor scaling address generator.
// A queue-fed driver offers restart/advance items, a monitor checks every
// output item against a pixel walker kept in the bench, while both sides
// stall at random and the four dimension registers move between phases.
// ============================================================================
module tb_bresenham_image_scale_addr;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM     = bisa_pkg::MAX_DIM_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int CFG_W       = bisa_pkg::CFG_W;
    localparam int IDX_W       = bisa_pkg::IDX_W;
    localparam int COORD_W     = bisa_pkg::COORD_W;
    localparam int ADDR_W      = bisa_pkg::ADDR_W;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_index;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               rep;
        logic               rend;
        logic               fend;
    } pixel_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_write  = 1'b0;
    logic [IDX_W-1:0]   cfg_index  = '0;
    logic [CFG_W-1:0]   cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               restart    = 1'b0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [ADDR_W-1:0]  source_index;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic               repeat_row;
    logic               row_end;
    logic               frame_end;

    logic   pending_restarts[$];
    pixel_t expected_pixels[$];
    int     mismatches        = 0;
    int     cycles            = 0;
    int     sender_idle_pct   = 16;
    int     receiver_idle_pct = 83;

    // register copies and the walker state
    logic [CFG_W-1:0]   reg_sw = bisa_pkg::SRC_W_RST;
    logic [CFG_W-1:0]   reg_sh = bisa_pkg::SRC_H_RST;
    logic [CFG_W-1:0]   reg_tw = bisa_pkg::TGT_W_RST;
    logic [CFG_W-1:0]   reg_th = bisa_pkg::TGT_H_RST;
    int unsigned        lat_sw = 1;
    int unsigned        lat_sh = 1;
    int unsigned        lat_tw = 1;
    int unsigned        lat_th = 1;
    logic [COORD_W-1:0] col_cnt   = '0;
    logic [COORD_W-1:0] row_cnt   = '0;
    logic [COORD_W-1:0] col_err   = '0;
    logic [COORD_W-1:0] row_err   = '0;
    logic [COORD_W-1:0] col_off   = '0;
    logic [ADDR_W-1:0]  row_base  = '0;
    logic [COORD_W-1:0] col_whole = '0;
    logic [COORD_W-1:0] col_part  = '0;
    logic [ADDR_W-1:0]  row_whole = '0;
    logic [COORD_W-1:0] row_part  = '0;
    logic               row_rep   = 1'b0;

    bresenham_image_scale_addr #(.MAX_DIM(MAX_DIM)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .source_index (source_index),
        .target_x     (target_x),
        .target_y     (target_y),
        .repeat_row   (repeat_row),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic void begin_frame();
        col_cnt  = '0;
        row_cnt  = '0;
        col_err  = '0;
        row_err  = '0;
        col_off  = '0;
        row_base = '0;
        row_rep  = 1'b0;
    endfunction

    // Walk one target pixel (or restart the frame) and return its address item.
    function automatic pixel_t next_pixel(input logic rs);
        int unsigned acc;
        int unsigned err;
        pixel_t      px;
        if (rs)
        begin
            lat_sw    = clamp_dim(reg_sw);
            lat_sh    = clamp_dim(reg_sh);
            lat_tw    = clamp_dim(reg_tw);
            lat_th    = clamp_dim(reg_th);
            acc       = lat_sw / lat_tw;
            col_whole = COORD_W'(acc);
            acc       = lat_sw % lat_tw;
            col_part  = COORD_W'(acc);
            acc       = (lat_sh / lat_th) * lat_sw;
            row_whole = ADDR_W'(acc);
            acc       = lat_sh % lat_th;
            row_part  = COORD_W'(acc);
            begin_frame();
        end
        else if (col_cnt + 32'd1 >= lat_tw)
        begin
            col_cnt = '0;
            col_off = '0;
            col_err = '0;
            if (row_cnt + 32'd1 >= lat_th)
                begin_frame();
            else
            begin
                acc = row_base + row_whole;
                err = row_err + row_part;
                if (err >= lat_th)
                begin
                    err = err - lat_th;
                    acc = acc + lat_sw;
                end
                row_rep  = (ADDR_W'(acc) == row_base);
                row_base = ADDR_W'(acc);
                row_err  = COORD_W'(err);
                row_cnt  = row_cnt + 1'b1;
            end
        end
        else
        begin
            acc = col_off + col_whole;
            err = col_err + col_part;
            if (err >= lat_tw)
            begin
                err = err - lat_tw;
                acc = acc + 1;
            end
            col_off = COORD_W'(acc);
            col_err = COORD_W'(err);
            col_cnt = col_cnt + 1'b1;
        end
        acc          = row_base + col_off;
        px.src_index = ADDR_W'(acc);
        px.x         = col_cnt;
        px.y         = row_cnt;
        px.rep       = row_rep;
        px.rend      = (col_cnt + 32'd1 >= lat_tw);
        px.fend      = px.rend && (row_cnt + 32'd1 >= lat_th);
        return px;
    endfunction

    // Driver: hold the item until taken, then maybe idle before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_pixels.push_back(next_pixel(restart));
            if (!in_valid || in_ready)
            begin
                if (pending_restarts.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    restart  <= pending_restarts.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_pixel();
        pixel_t got;
        pixel_t want;
        got.src_index = source_index;
        got.x         = target_x;
        got.y         = target_y;
        got.rep       = repeat_row;
        got.rend      = row_end;
        got.fend      = frame_end;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: index %0d x %0d y %0d rep %0b rend %0b fend %0b",
                         got.src_index, got.x, got.y, got.rep, got.rend, got.fend);
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected index %0d x %0d y %0d rep %0b rend %0b fend %0b",
                             want.src_index, want.x, want.y, want.rep, want.rend, want.fend);
                    $display("          got index %0d x %0d y %0d rep %0b rend %0b fend %0b",
                             got.src_index, got.x, got.y, got.rep, got.rend, got.fend);
                end
            end
        end
    endtask

    // Monitor: take output items and stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_pixel();
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            bisa_pkg::REG_SRC_W: reg_sw = val;
            bisa_pkg::REG_SRC_H: reg_sh = val;
            bisa_pkg::REG_TGT_W: reg_tw = val;
            bisa_pkg::REG_TGT_H: reg_th = val;
            default:   ;
        endcase
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                              input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
        write_reg(bisa_pkg::REG_SRC_W, sw);
        write_reg(bisa_pkg::REG_SRC_H, sh);
        write_reg(bisa_pkg::REG_TGT_W, tw);
        write_reg(bisa_pkg::REG_TGT_H, th);
    endtask

    // Wait until every offered item is taken and every output item checked.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_restarts.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_items(input logic items[$]);
        @(negedge clk);
        foreach (items[i])
            pending_restarts.push_back(items[i]);
        wait_drained();
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 14)
            return CFG_W'($urandom_range(4095, MAX_DIM + 1));
        if (r < 20)
            return ($urandom_range(1) != 0) ? CFG_W'(MAX_DIM) : CFG_W'(1);
        if (r < 32)
            return CFG_W'($urandom_range(MAX_DIM, 1));
        return CFG_W'($urandom_range(12, 1));
    endfunction

    initial
    begin : stimulus
        logic items[$];
        int   mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // advance before any restart, then the default 800x480 frame
        run_items('{1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
        // zero dimensions; the first advance still walks the old frame
        write_dims('0, '0, '0, '0);
        run_items('{1'b0, 1'b1, 1'b0});
        // oversized source on a 1x1 target: both whole steps overflow
        write_dims(CFG_W'(4095), CFG_W'(MAX_DIM), CFG_W'(1), CFG_W'(1));
        run_items('{1'b1, 1'b0});
        // 5x2 onto 2x3: repeated row, row and frame ends, wrap to a new frame
        write_dims(CFG_W'(5), CFG_W'(2), CFG_W'(2), CFG_W'(3));
        run_items('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
        // largest frame, restarted mid-row
        write_dims(CFG_W'(MAX_DIM), CFG_W'(MAX_DIM), CFG_W'(MAX_DIM), CFG_W'(MAX_DIM));
        run_items('{1'b1, 1'b0, 1'b1});

        for (int phase = 0; phase < 9; phase++)
        begin
            mode = phase / 3;
            sender_idle_pct   = (mode == 0) ? 16 : (mode == 1) ? 83 : 0;
            receiver_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 16 : 0;
            if ($urandom_range(4) != 0) write_reg(bisa_pkg::REG_SRC_W, pick_dim());
            if ($urandom_range(4) != 0) write_reg(bisa_pkg::REG_SRC_H, pick_dim());
            if ($urandom_range(4) != 0) write_reg(bisa_pkg::REG_TGT_W, pick_dim());
            if ($urandom_range(4) != 0) write_reg(bisa_pkg::REG_TGT_H, pick_dim());
            // two runs per phase; the drain in between pauses the sender
            for (int half = 0; half < 2; half++)
            begin
                items = {};
                for (int i = 0; i < 22 + half; i++)
                begin
                    if (i == 0 && half == 0)
                        items.push_back($urandom_range(3) != 0);
                    else
                        items.push_back($urandom_range(24) == 0);
                end
                run_items(items);
            end
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/bisa_pkg.sv
sv/bisa_ctrl.sv
sv/bisa_dpath.sv
sv/bresenham_image_scale_addr.sv
tb/sv/tb_bresenham_image_scale_addr.sv
